// ===== src/vsgm_pkg.sv =====
// Package for the voxel slice greedy mesher: quad and result types, face and command codes.
// No dependencies; every other file of the block uses it by scoped names.
package vsgm_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PX = 3'd4;
    localparam logic [2:0] FACE_NX = 3'd5;

    localparam int BLK_W    = 8;
    localparam int COORD_W  = 5;
    localparam int SIZE_W   = 6;
    localparam int PACKED_W = 36;

    // quad as found in slice coordinates
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] slice;
        logic [2:0]         face;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [BLK_W-1:0]   blk;
    } t_quad;

    // quad mapped to world axes, as it leaves the block
    typedef struct packed {
        logic                found;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [2:0]          face;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [BLK_W-1:0]    blk;
        logic [PACKED_W-1:0] packed_word;
    } t_result;

endpackage

// ===== src/voxel_slice_greedy_mesher_unit.sv =====
// Voxel slice greedy mesher, top level. Cell write: no result. Fetch, one item at a time
// through the single mask port: scan the entries, grow along the row, grow down the rows,
// clear the covered entries, hand over (held while the result register is stalled); an
// exhausted fetch scans and hands over. After reset a clearing pass zeroes all
// 2**(2*clog2(SIDE)) mask entries (1024 at SIDE=32), during which no transfer is accepted.
// Reset is synchronous, active low.
module voxel_slice_greedy_mesher_unit #(
    parameter int SIDE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic [7:0]  i_block_id,
    input  logic [7:0]  i_neighbor_id,
    input  logic [2:0]  i_face,
    input  logic [4:0]  i_slice_pos,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [4:0]  o_quad_x,
    output logic [4:0]  o_quad_y,
    output logic [4:0]  o_quad_z,
    output logic [2:0]  o_quad_face,
    output logic [5:0]  o_quad_width,
    output logic [5:0]  o_quad_height,
    output logic [7:0]  o_quad_block,
    output logic [35:0] o_packed_quad
);

    // Address bits per axis, counter width able to hold SIDE itself.
    localparam int AB = $clog2(SIDE);
    localparam int AW = 2 * AB;
    localparam int RB = $clog2(SIDE + 1);

    localparam logic [RB-1:0] SIDE_R  = RB'(SIDE);
    localparam logic [RB-1:0] SIDE_M1 = RB'(SIDE - 1);
    localparam logic [RB-1:0] ONE_R   = RB'(1);
    localparam logic [AW-1:0] CLR_END = {AW{1'b1}};

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // zero the mask after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // take a transfer
    localparam logic [2:0] S_SCAN  = 3'd2;  // look for the next nonzero entry
    localparam logic [2:0] S_WID   = 3'd3;  // grow along the row
    localparam logic [2:0] S_HGT   = 3'd4;  // grow down the rows
    localparam logic [2:0] S_ZERO  = 3'd5;  // clear the covered entries
    localparam logic [2:0] S_DONE  = 3'd6;  // hand the result to the output register

    logic [2:0]    r_state,    n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [RB-1:0] r_cur_row,  n_cur_row;
    logic [RB-1:0] r_cur_col,  n_cur_col;
    logic [2:0]    r_face,     n_face;
    logic [4:0]    r_slice,    n_slice;
    // read issue position
    logic [RB-1:0] r_irow,     n_irow;
    logic [RB-1:0] r_icol,     n_icol;
    // tag of the read whose data arrives this cycle
    logic          r_rd_vld,   n_rd_vld;
    logic          r_rd_last,  n_rd_last;
    logic [RB-1:0] r_rd_row,   n_rd_row;
    logic [RB-1:0] r_rd_col,   n_rd_col;
    // quad under construction
    logic [RB-1:0] r_base_row, n_base_row;
    logic [RB-1:0] r_base_col, n_base_col;
    logic [7:0]    r_blk,      n_blk;
    logic [RB-1:0] r_w,        n_w;
    logic [RB-1:0] r_h,        n_h;
    logic          r_found,    n_found;
    logic [RB-1:0] r_zrow,     n_zrow;
    logic [RB-1:0] r_zcol,     n_zcol;
    // output register
    logic              r_out_vld, n_out_vld;
    vsgm_pkg::t_result r_out,     n_out;

    // memory port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic              in_acc;
    logic              out_free;
    logic [RB-1:0]     last_col;
    logic [RB-1:0]     last_row;
    logic [RB-1:0]     end_col;
    logic              cell_in;
    vsgm_pkg::t_quad   quad;
    vsgm_pkg::t_result packed_res;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;

    assign end_col  = r_base_col + r_w;
    assign last_col = end_col - ONE_R;
    assign last_row = r_base_row + r_h - ONE_R;
    assign cell_in  = ({1'b0, i_cell_row} < 6'(SIDE)) && ({1'b0, i_cell_col} < 6'(SIDE));

    vsgm_mask_ram #(
        .AW (AW)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        quad.found  = r_found;
        quad.row    = 5'(r_base_row);
        quad.col    = 5'(r_base_col);
        quad.slice  = r_slice;
        quad.face   = r_face;
        quad.width  = 6'(r_w);
        quad.height = 6'(r_h);
        quad.blk    = r_blk;
    end

    vsgm_quad_pack u_pack (
        .i_quad   (quad),
        .o_result (packed_res)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_face     = r_face;
        n_slice    = r_slice;
        n_irow     = r_irow;
        n_icol     = r_icol;
        n_rd_vld   = 1'b0;
        n_rd_last  = r_rd_last;
        n_rd_row   = r_rd_row;
        n_rd_col   = r_rd_col;
        n_base_row = r_base_row;
        n_base_col = r_base_col;
        n_blk      = r_blk;
        n_w        = r_w;
        n_h        = r_h;
        n_found    = r_found;
        n_zrow     = r_zrow;
        n_zcol     = r_zcol;
        n_out_vld  = r_out_vld && i_stall;
        n_out      = r_out;

        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = {r_irow[AB-1:0], r_icol[AB-1:0]};

        unique case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == vsgm_pkg::CMD_WRITE) begin
                        // store the visible block, rewind the cursor
                        wr_en     = cell_in;
                        wr_addr   = {i_cell_row[AB-1:0], i_cell_col[AB-1:0]};
                        wr_data   = (i_block_id != '0 && i_neighbor_id == '0) ?
                                    i_block_id : '0;
                        n_cur_row = '0;
                        n_cur_col = '0;
                    end else begin
                        n_face  = i_face;
                        n_slice = i_slice_pos;
                        n_irow  = r_cur_row;
                        n_icol  = r_cur_col;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_vld && rd_data != '0) begin
                    n_base_row = r_rd_row;
                    n_base_col = r_rd_col;
                    n_blk      = rd_data;
                    n_w        = ONE_R;
                    n_h        = ONE_R;
                    n_irow     = r_rd_row;
                    n_icol     = r_rd_col + ONE_R;
                    n_state    = S_WID;
                end else if (r_irow == SIDE_R) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_row = r_irow;
                    n_rd_col = r_icol;
                    if (r_icol == SIDE_M1) begin
                        n_icol = '0;
                        n_irow = r_irow + ONE_R;
                    end else begin
                        n_icol = r_icol + ONE_R;
                    end
                end
            end
            S_WID: begin
                if ((r_rd_vld && rd_data != r_blk) || (!r_rd_vld && r_icol == SIDE_R)) begin
                    n_irow  = r_base_row + ONE_R;
                    n_icol  = r_base_col;
                    n_state = S_HGT;
                end else begin
                    if (r_rd_vld) begin
                        n_w = r_w + ONE_R;
                    end
                    if (r_icol != SIDE_R) begin
                        rd_en    = 1'b1;
                        n_rd_vld = 1'b1;
                        n_icol   = r_icol + ONE_R;
                    end
                end
            end
            S_HGT: begin
                if ((r_rd_vld && rd_data != r_blk) || (!r_rd_vld && r_irow == SIDE_R)) begin
                    n_zrow  = r_base_row;
                    n_zcol  = r_base_col;
                    n_state = S_ZERO;
                end else begin
                    if (r_rd_vld && r_rd_last) begin
                        n_h = r_h + ONE_R;
                    end
                    if (r_irow != SIDE_R) begin
                        rd_en     = 1'b1;
                        n_rd_vld  = 1'b1;
                        n_rd_last = (r_icol == last_col);
                        if (r_icol == last_col) begin
                            n_icol = r_base_col;
                            n_irow = r_irow + ONE_R;
                        end else begin
                            n_icol = r_icol + ONE_R;
                        end
                    end
                end
            end
            S_ZERO: begin
                wr_en   = 1'b1;
                wr_addr = {r_zrow[AB-1:0], r_zcol[AB-1:0]};
                if (r_zcol == last_col) begin
                    n_zcol = r_base_col;
                    if (r_zrow == last_row) begin
                        n_found = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_zrow = r_zrow + ONE_R;
                    end
                end else begin
                    n_zcol = r_zcol + ONE_R;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = packed_res;
                    n_state   = S_IDLE;
                    if (!r_found) begin
                        n_cur_row = SIDE_R;
                        n_cur_col = '0;
                    end else if (end_col == SIDE_R) begin
                        n_cur_row = r_base_row + ONE_R;
                        n_cur_col = '0;
                    end else begin
                        n_cur_row = r_base_row;
                        n_cur_col = end_col;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_face     <= n_face;
        r_slice    <= n_slice;
        r_irow     <= n_irow;
        r_icol     <= n_icol;
        r_rd_last  <= n_rd_last;
        r_rd_row   <= n_rd_row;
        r_rd_col   <= n_rd_col;
        r_base_row <= n_base_row;
        r_base_col <= n_base_col;
        r_blk      <= n_blk;
        r_w        <= n_w;
        r_h        <= n_h;
        r_found    <= n_found;
        r_zrow     <= n_zrow;
        r_zcol     <= n_zcol;
        r_out      <= n_out;
    end

    assign o_valid       = r_out_vld;
    assign o_found       = r_out.found;
    assign o_quad_x      = r_out.x;
    assign o_quad_y      = r_out.y;
    assign o_quad_z      = r_out.z;
    assign o_quad_face   = r_out.face;
    assign o_quad_width  = r_out.width;
    assign o_quad_height = r_out.height;
    assign o_quad_block  = r_out.blk;
    assign o_packed_quad = r_out.packed_word;

    // The sequencer never reads and writes the mask in the same cycle.
    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("mask read and write in the same cycle");

    // An exhausted slice gives an all-zero result.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_packed_quad == '0 && o_quad_width == '0))
        else $error("exhausted fetch carries nonzero fields");

    // A found quad covers at least one cell and never an empty block.
    a_quad_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |->
        (o_quad_width != '0 && o_quad_height != '0 && o_quad_block != '0))
        else $error("found quad is empty");

    // A fetch transfer starts the scan in the next cycle.
    a_fetch_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd == vsgm_pkg::CMD_FETCH) |=> (r_state == S_SCAN))
        else $error("fetch did not start a scan");

endmodule

// ===== src/vsgm_mask_ram.sv =====
// Visible-face mask memory: one write port, one read port, registered read data.
// Depends on vsgm_pkg for the entry width.
module vsgm_mask_ram #(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [vsgm_pkg::BLK_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [vsgm_pkg::BLK_W-1:0] o_rdata
);

    logic [vsgm_pkg::BLK_W-1:0] r_mem [2**AW];
    logic [vsgm_pkg::BLK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/vsgm_quad_pack.sv =====
// Maps a quad from slice coordinates to world axes by face and packs the 36-bit word.
// Depends on vsgm_pkg for t_quad, t_result and the face codes.
module vsgm_quad_pack (
    input  vsgm_pkg::t_quad   i_quad,
    output vsgm_pkg::t_result o_result
);

    logic [vsgm_pkg::COORD_W-1:0] x;
    logic [vsgm_pkg::COORD_W-1:0] y;
    logic [vsgm_pkg::COORD_W-1:0] z;
    logic [vsgm_pkg::COORD_W-1:0] w_m1;
    logic [vsgm_pkg::COORD_W-1:0] h_m1;

    always_comb begin
        unique case (i_quad.face)
            vsgm_pkg::FACE_PY, vsgm_pkg::FACE_NY: begin
                x = i_quad.col;
                y = i_quad.slice;
                z = i_quad.row;
            end
            vsgm_pkg::FACE_PX, vsgm_pkg::FACE_NX: begin
                x = i_quad.slice;
                y = i_quad.row;
                z = i_quad.col;
            end
            default: begin
                x = i_quad.col;
                y = i_quad.row;
                z = i_quad.slice;
            end
        endcase
    end

    assign w_m1 = vsgm_pkg::COORD_W'(i_quad.width - vsgm_pkg::SIZE_W'(1));
    assign h_m1 = vsgm_pkg::COORD_W'(i_quad.height - vsgm_pkg::SIZE_W'(1));

    always_comb begin
        if (i_quad.found) begin
            o_result.found       = 1'b1;
            o_result.x           = x;
            o_result.y           = y;
            o_result.z           = z;
            o_result.face        = i_quad.face;
            o_result.width       = i_quad.width;
            o_result.height      = i_quad.height;
            o_result.blk         = i_quad.blk;
            o_result.packed_word = {i_quad.blk, h_m1, w_m1, i_quad.face, z, y, x};
        end else begin
            // drop every field when the slice is exhausted
            o_result = '0;
        end
    end

endmodule

// ===== verif/voxel_slice_greedy_mesher_unit_checker.sv =====
// Checker for the voxel slice greedy mesher: watches both channels, predicts each fetch
// result from its own copy of the visible mask and compares it field by field.
// Depends on vsgm_pkg for the result type and the command and face codes.
module voxel_slice_greedy_mesher_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic [7:0]  i_block_id,
    input  logic [7:0]  i_neighbor_id,
    input  logic [2:0]  i_face,
    input  logic [4:0]  i_slice_pos,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_found,
    input  logic [4:0]  i_quad_x,
    input  logic [4:0]  i_quad_y,
    input  logic [4:0]  i_quad_z,
    input  logic [2:0]  i_quad_face,
    input  logic [5:0]  i_quad_width,
    input  logic [5:0]  i_quad_height,
    input  logic [7:0]  i_quad_block,
    input  logic [35:0] i_packed_quad,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = 32;
    localparam int CELLS = SIDE * SIDE;

    logic [7:0]        visible_cells [CELLS];
    int                scan_pos;
    int                quads_seen;
    vsgm_pkg::t_result expected_quads [$];

    task automatic report_fault(input string msg);
        $display("[%0t] %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [35:0] got,
                               input logic [35:0] want);
        if (got !== want)
            report_fault($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   quads_seen, name, got, want));
    endtask

    // Scan forward from the cursor, grow the quad along the row then down the rows,
    // clear what it covers and map the origin onto the face axes.
    function automatic vsgm_pkg::t_result mesh_next_quad(input logic [2:0] face,
                                                         input logic [4:0] slice);
        vsgm_pkg::t_result q;
        logic [7:0]        tag;
        int                row, col, w, h, r, k;
        bit                grow;
        q = '0;
        while (scan_pos < CELLS) begin
            row = scan_pos / SIDE;
            col = scan_pos % SIDE;
            tag = visible_cells[row * SIDE + col];
            if (tag != 0) begin
                w = 1;
                h = 1;
                while (col + w < SIDE && visible_cells[row * SIDE + col + w] == tag)
                    w++;
                grow = 1'b1;
                while (grow && row + h < SIDE) begin
                    for (k = 0; k < w; k++)
                        if (visible_cells[(row + h) * SIDE + col + k] != tag)
                            grow = 1'b0;
                    if (grow)
                        h++;
                end
                for (r = 0; r < h; r++)
                    for (k = 0; k < w; k++)
                        visible_cells[(row + r) * SIDE + col + k] = '0;
                scan_pos = row * SIDE + col + w;

                q.found  = 1'b1;
                q.face   = face;
                q.width  = 6'(w);
                q.height = 6'(h);
                q.blk    = tag;
                case (face)
                    vsgm_pkg::FACE_PY, vsgm_pkg::FACE_NY: begin
                        q.x = 5'(col);
                        q.y = slice;
                        q.z = 5'(row);
                    end
                    vsgm_pkg::FACE_PX, vsgm_pkg::FACE_NX: begin
                        q.x = slice;
                        q.y = 5'(row);
                        q.z = 5'(col);
                    end
                    default: begin
                        q.x = 5'(col);
                        q.y = 5'(row);
                        q.z = slice;
                    end
                endcase
                q.packed_word = {tag, 5'(h - 1), 5'(w - 1), face, q.z, q.y, q.x};
                return q;
            end
            scan_pos++;
        end
        // slice exhausted: everything zero, cursor parks at the end
        return q;
    endfunction

    always @(posedge i_clk) begin : monitor
        vsgm_pkg::t_result want;
        if (!i_rst_n) begin
            foreach (visible_cells[i]) visible_cells[i] = '0;
            scan_pos     = 0;
            quads_seen   = 0;
            o_fail_count = 0;
            expected_quads.delete();
        end else begin
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (i_cmd == vsgm_pkg::CMD_WRITE) begin
                    visible_cells[i_cell_row * SIDE + i_cell_col] =
                        (i_block_id != 0 && i_neighbor_id == 0) ? i_block_id : 8'd0;
                    scan_pos = 0;
                end else begin
                    expected_quads.insert(expected_quads.size(),
                                          mesh_next_quad(i_face, i_slice_pos));
                end
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_quads.size() == 0) begin
                    report_fault($sformatf("result %0d arrived with nothing outstanding",
                                           quads_seen));
                end else begin
                    want = expected_quads.pop_front();
                    check_field("found",       36'(i_found),       36'(want.found));
                    check_field("quad_x",      36'(i_quad_x),      36'(want.x));
                    check_field("quad_y",      36'(i_quad_y),      36'(want.y));
                    check_field("quad_z",      36'(i_quad_z),      36'(want.z));
                    check_field("quad_face",   36'(i_quad_face),   36'(want.face));
                    check_field("quad_width",  36'(i_quad_width),  36'(want.width));
                    check_field("quad_height", 36'(i_quad_height), 36'(want.height));
                    check_field("quad_block",  36'(i_quad_block),  36'(want.blk));
                    check_field("packed_quad", i_packed_quad,      want.packed_word);
                end
                quads_seen++;
            end
        end
        o_pending = expected_quads.size();
    end

endmodule

// ===== verif/voxel_slice_greedy_mesher_unit_test.sv =====
// Testbench top for the voxel slice greedy mesher: clock, reset, cell and fetch stimulus,
// random idling on both channels and the verdict. Depends on vsgm_pkg, the block and
// voxel_slice_greedy_mesher_unit_checker, which does all prediction and comparison.
module voxel_slice_greedy_mesher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Face codes not named in the package; six and seven are the spare codes.
    localparam logic [2:0] FACE_PZ   = 3'd0;
    localparam logic [2:0] FACE_NZ   = 3'd1;
    localparam logic [2:0] FACE_SPR6 = 3'd6;
    localparam logic [2:0] FACE_SPR7 = 3'd7;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_START   = 300;      // transfers in before the long hold-off
    localparam int HOLD_CYCLES  = 1500;
    // A fetch can scan, check and clear the whole 1024-entry mask.
    localparam int DRAIN_CYCLES = 3200;
    localparam int RUN_LIMIT    = 10_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [4:0]  i_cell_row;
    logic [4:0]  i_cell_col;
    logic [7:0]  i_block_id;
    logic [7:0]  i_neighbor_id;
    logic [2:0]  i_face;
    logic [4:0]  i_slice_pos;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [4:0]  o_quad_x;
    logic [4:0]  o_quad_y;
    logic [4:0]  o_quad_z;
    logic [2:0]  o_quad_face;
    logic [5:0]  o_quad_width;
    logic [5:0]  o_quad_height;
    logic [7:0]  o_quad_block;
    logic [35:0] o_packed_quad;

    logic        rx_stall;          // per-result random stall of the receiver
    logic        hold_off;          // the one long receiver hold-off
    int          items_sent;
    int          tx_burst_left;
    int          rx_burst_left;
    int          cycle_count;
    int          quads_outstanding;
    int          fail_count;

    // The receiver's stall is its own random stall or the long hold-off.
    assign i_stall = rx_stall | hold_off;

    voxel_slice_greedy_mesher_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_block_id    (i_block_id),
        .i_neighbor_id (i_neighbor_id),
        .i_face        (i_face),
        .i_slice_pos   (i_slice_pos),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_quad_x      (o_quad_x),
        .o_quad_y      (o_quad_y),
        .o_quad_z      (o_quad_z),
        .o_quad_face   (o_quad_face),
        .o_quad_width  (o_quad_width),
        .o_quad_height (o_quad_height),
        .o_quad_block  (o_quad_block),
        .o_packed_quad (o_packed_quad)
    );

    voxel_slice_greedy_mesher_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_block_id    (i_block_id),
        .i_neighbor_id (i_neighbor_id),
        .i_face        (i_face),
        .i_slice_pos   (i_slice_pos),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_found       (o_found),
        .i_quad_x      (o_quad_x),
        .i_quad_y      (o_quad_y),
        .i_quad_z      (o_quad_z),
        .i_quad_face   (o_quad_face),
        .i_quad_width  (o_quad_width),
        .i_quad_height (o_quad_height),
        .i_quad_block  (o_quad_block),
        .i_packed_quad (o_packed_quad),
        .o_pending     (quads_outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("voxel_slice_greedy_mesher_unit: mismatch");
        $finish;
    end

    // Offer one transfer. Draw the gap first (none inside a burst stretch), hold the
    // payload steady while stalled, and return in the time step of acceptance with
    // valid still high so that a back-to-back item needs no second assignment.
    // Stall is sampled at the falling edge, where everything driven at the rising edge
    // has settled, so acceptance never hangs on event order.
    task automatic send_item(input logic cmd, input logic [4:0] row, input logic [4:0] col,
                             input logic [7:0] blk, input logic [7:0] nb,
                             input logic [2:0] face, input logic [4:0] slice);
        int gap;
        bit taken;
        if (tx_burst_left > 0) begin
            gap = 0;
            tx_burst_left--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0)
                tx_burst_left = $urandom_range(15, 40);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_cell_row    <= row;
        i_cell_col    <= col;
        i_block_id    <= blk;
        i_neighbor_id <= nb;
        i_face        <= face;
        i_slice_pos   <= slice;
        do begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    // Fields that a command ignores still carry random values.
    task automatic write_cell(input logic [4:0] row, input logic [4:0] col,
                              input logic [7:0] blk, input logic [7:0] nb);
        send_item(vsgm_pkg::CMD_WRITE, row, col, blk, nb,
                  3'($urandom_range(0, 7)), 5'($urandom));
    endtask

    task automatic fetch_quad(input logic [2:0] face, input logic [4:0] slice);
        send_item(vsgm_pkg::CMD_FETCH, 5'($urandom), 5'($urandom), 8'($urandom),
                  8'($urandom), face, slice);
    endtask

    // Receiver: before each result transfer, stall for a drawn number of cycles
    // (none inside a burst stretch), then take the next result offered.
    initial begin : receiver
        int  n;
        bit  took;
        rx_stall      <= 1'b0;
        rx_burst_left = 0;
        @(posedge i_clk);
        forever begin
            if (rx_burst_left > 0) begin
                n = 0;
                rx_burst_left--;
            end else begin
                n = $urandom_range(0, 11);
                if ($urandom_range(0, 29) == 0)
                    rx_burst_left = $urandom_range(15, 40);
            end
            if (n > 0) begin
                rx_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                rx_stall <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                took = (o_valid === 1'b1) && (i_stall === 1'b0);
                @(posedge i_clk);
            end while (!took);
        end
    end

    // Long hold-off: the sender keeps offering meanwhile, so the block backs up and
    // raises its own stall.
    initial begin
        hold_off <= 1'b0;
        wait (items_sent >= HOLD_START);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        int         random_goal, kind, nrect, r0, c0, rh, rw, fetches, r, c, j;
        logic [7:0] pal_a, pal_b, blk;

        items_sent    = 0;
        tx_burst_left = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= vsgm_pkg::CMD_WRITE;
        i_cell_row    <= '0;
        i_cell_col    <= '0;
        i_block_id    <= '0;
        i_neighbor_id <= '0;
        i_face        <= '0;
        i_slice_pos   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its mask after reset; its stall holds us off meanwhile.

        // Empty slice: found low, and the cursor stays parked on a second try.
        fetch_quad(FACE_PZ, 5'd0);
        fetch_quad(FACE_SPR7, 5'd31);

        // A 2x2 quad of the top block in the corner, other corners, a covered face
        // (neighbour solid) and an empty cell.
        write_cell(5'd0, 5'd0, 8'd255, 8'd0);
        write_cell(5'd0, 5'd1, 8'd255, 8'd0);
        write_cell(5'd1, 5'd0, 8'd255, 8'd0);
        write_cell(5'd1, 5'd1, 8'd255, 8'd0);
        write_cell(5'd31, 5'd31, 8'd1, 8'd0);
        write_cell(5'd31, 5'd30, 8'd1, 8'd255);
        write_cell(5'd5, 5'd5, 8'd0, 8'd0);
        write_cell(5'd0, 5'd31, 8'd128, 8'd0);
        write_cell(5'd31, 5'd0, 8'd128, 8'd0);
        fetch_quad(FACE_PZ, 5'd31);
        fetch_quad(FACE_NZ, 5'd0);
        fetch_quad(vsgm_pkg::FACE_PY, 5'd17);
        fetch_quad(vsgm_pkg::FACE_NY, 5'd31);
        fetch_quad(vsgm_pkg::FACE_PX, 5'd3);

        // Neighbouring cells of different blocks must not merge; cover the X faces
        // and both spare face codes.
        write_cell(5'd10, 5'd10, 8'd7, 8'd0);
        write_cell(5'd10, 5'd11, 8'd8, 8'd0);
        write_cell(5'd11, 5'd10, 8'd7, 8'd0);
        fetch_quad(vsgm_pkg::FACE_NX, 5'd31);
        fetch_quad(FACE_SPR6, 5'd21);
        fetch_quad(vsgm_pkg::FACE_PX, 5'd0);
        fetch_quad(FACE_SPR7, 5'd10);

        random_goal = items_sent + RANDOM_ITEMS;

        // The largest quads, once each: a full row and a full column.
        pal_a = 8'($urandom_range(1, 255));
        r0    = $urandom_range(0, 31);
        for (c = 0; c < 32; c++)
            write_cell(5'(r0), 5'(c), pal_a, 8'd0);
        for (j = 0; j < 3; j++)
            fetch_quad(3'($urandom_range(0, 7)), 5'($urandom));
        pal_a = 8'($urandom_range(1, 255));
        c0    = $urandom_range(0, 31);
        for (r = 0; r < 32; r++)
            write_cell(5'(r), 5'(c0), pal_a, 8'd0);
        for (j = 0; j < 3; j++)
            fetch_quad(3'($urandom_range(0, 7)), 5'($urandom));

        // Mostly well-formed episodes: paint a few rectangles from a two-block palette
        // so that they merge or split, then fetch until the slice is about drained.
        // Mixed in: stray fetches mid-paint, covered or empty cells, pure noise, sweeps.
        while (items_sent < random_goal) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                for (j = $urandom_range(1, 6); j > 0; j--)
                    send_item(1'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
                              8'($urandom), 3'($urandom), 5'($urandom));
            end else if (kind == 2) begin
                for (j = 0; j < 6; j++)
                    fetch_quad(3'($urandom_range(0, 7)), 5'($urandom));
            end else begin
                pal_a = 8'($urandom_range(1, 255));
                pal_b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : pal_a;
                nrect = $urandom_range(1, 3);
                for (j = 0; j < nrect; j++) begin
                    r0  = $urandom_range(0, 31);
                    c0  = $urandom_range(0, 31);
                    rh  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                      : $urandom_range(1, 4);
                    rw  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                      : $urandom_range(1, 4);
                    blk = $urandom_range(0, 1) ? pal_a : pal_b;
                    for (r = r0; r < r0 + rh && r < 32; r++)
                        for (c = c0; c < c0 + rw && c < 32; c++) begin
                            if ($urandom_range(0, 11) == 0)
                                write_cell(5'(r), 5'(c),
                                           $urandom_range(0, 1) ? 8'd0 : blk,
                                           8'($urandom_range(1, 255)));
                            else
                                write_cell(5'(r), 5'(c), blk, 8'd0);
                            if ($urandom_range(0, 39) == 0)
                                fetch_quad(3'($urandom_range(0, 7)), 5'($urandom));
                        end
                end
                for (fetches = nrect + $urandom_range(0, 3); fetches > 0; fetches--)
                    fetch_quad(3'($urandom_range(0, 7)), 5'($urandom));
            end
        end

        // Drop valid, drain the outstanding results, then watch for strays.
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (quads_outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("voxel_slice_greedy_mesher_unit: match");
        else
            $display("voxel_slice_greedy_mesher_unit: mismatch");
        $finish;
    end

endmodule
